// ===== design/ris_pkg.sv =====
// shared types and widths for the ray against sphere intersection pipeline
// no dependencies
`default_nettype none
package ris_pkg;

  localparam int COORD_W = 32;
  localparam int DIR_W   = 16;
  localparam int DIR_FRAC = 15;
  localparam int RAD_W   = 31;
  localparam int L_W     = COORD_W + 1;
  localparam int DOT_W   = 50;
  localparam int TCA_W   = DOT_W - DIR_FRAC;
  localparam int TM_W    = TCA_W - 1;
  localparam int LL_W    = 66;
  localparam int RR_W    = 2 * RAD_W;
  localparam int TM2_W   = 2 * TM_W;
  localparam int DIFF_W  = 72;
  localparam int ROOT_W  = 35;
  localparam int X_W     = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 3;
  localparam int T_W     = TCA_W + 2;
  localparam int DIST_W  = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } cfg_reg_t;

  // data handed from one square root cell to the next
  typedef struct packed {
    logic                     valid;
    logic                     neg;
    logic signed [TCA_W-1:0]  tca;
    logic [X_W-1:0]           x;
    logic [REM_W-1:0]         rem;
    logic [ROOT_W-1:0]        root;
  } sqrt_word_t;

endpackage
`default_nettype wire

// ===== design/ray_sphere_intersect.sv =====
// top level: ray against sphere test, config registers, root chain, output stage
// depends on ris_pkg, ris_front, ris_sqrt_cell
`default_nettype none
// channel  | handshake           | payload
// ray in   | in_valid / in_stall | origin_x/y/z, dir_x/y/z
// hit out  | out_valid/out_stall | hit, distance
// config   | cfg_we              | cfg_index, cfg_data
//
// one ray per cycle sustained while out_stall stays low; 6 front stages, 35 root cells
// and 1 output register, most of the depth in the 35 cell floor square root chain
// synchronous reset clears all valid bits; radius resets to 1.0, centre to 0
// a stalled result freezes the whole pipeline, and in_stall follows from it
module ray_sphere_intersect (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [ris_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ris_pkg::COORD_W-1:0]        cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [ris_pkg::COORD_W-1:0] origin_x,
  input  wire logic signed [ris_pkg::COORD_W-1:0] origin_y,
  input  wire logic signed [ris_pkg::COORD_W-1:0] origin_z,
  input  wire logic signed [ris_pkg::DIR_W-1:0]   dir_x,
  input  wire logic signed [ris_pkg::DIR_W-1:0]   dir_y,
  input  wire logic signed [ris_pkg::DIR_W-1:0]   dir_z,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    hit,
  output logic [ris_pkg::DIST_W-1:0]              distance
);
  import ris_pkg::*;

  // sphere registers
  logic signed [COORD_W-1:0] center_x, center_y, center_z;
  logic [RAD_W-1:0]          sphere_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      sphere_radius <= RAD_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: center_x      <= cfg_data;
        REG_CENTER_Y: center_y      <= cfg_data;
        REG_CENTER_Z: center_z      <= cfg_data;
        REG_RADIUS:   sphere_radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // everything advances unless a result sits unclaimed
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  sqrt_word_t chain [ROOT_W+1];

  ris_front u_front (
    .clk, .rst, .en,
    .in_take(in_valid && en),
    .center_x, .center_y, .center_z, .sphere_radius,
    .origin_x, .origin_y, .origin_z,
    .dir_x, .dir_y, .dir_z,
    .head(chain[0])
  );

  // one root bit per cell, most significant first
  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    ris_sqrt_cell u_cell (
      .clk, .rst, .en,
      .d_in(chain[i]),
      .d_out(chain[i+1])
    );
  end

  // pick the nearest non-negative root, saturate
  sqrt_word_t      tail;
  logic signed [T_W-1:0] t0, t1, t_sel;
  logic            t_hit;
  logic [DIST_W-1:0] t_dist;

  always_comb begin
    tail  = chain[ROOT_W];
    t0    = T_W'(tail.tca) - T_W'(tail.root);
    t1    = T_W'(tail.tca) + T_W'(tail.root);
    t_sel = t0[T_W-1] ? t1 : t0;
    t_hit = !tail.neg && !t1[T_W-1];
    if (!t_hit) begin
      t_dist = '0;
    end else if (t_sel[T_W-2:DIST_W] != '0) begin
      t_dist = '1;
    end else begin
      t_dist = t_sel[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tail.valid;
    end
    if (en) begin
      hit      <= t_hit;
      distance <= t_dist;
    end
  end

endmodule
`default_nettype wire

// ===== design/ris_front.sv =====
// front pipeline: ray to sphere vector, dot products, squares, r^2 - d2
// depends on ris_pkg
`default_nettype none
module ris_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire logic                               in_take,
  input  wire logic signed [ris_pkg::COORD_W-1:0] center_x,
  input  wire logic signed [ris_pkg::COORD_W-1:0] center_y,
  input  wire logic signed [ris_pkg::COORD_W-1:0] center_z,
  input  wire logic [ris_pkg::RAD_W-1:0]          sphere_radius,
  input  wire logic signed [ris_pkg::COORD_W-1:0] origin_x,
  input  wire logic signed [ris_pkg::COORD_W-1:0] origin_y,
  input  wire logic signed [ris_pkg::COORD_W-1:0] origin_z,
  input  wire logic signed [ris_pkg::DIR_W-1:0]   dir_x,
  input  wire logic signed [ris_pkg::DIR_W-1:0]   dir_y,
  input  wire logic signed [ris_pkg::DIR_W-1:0]   dir_z,
  output ris_pkg::sqrt_word_t                     head
);
  import ris_pkg::*;

  logic [5:0] vld;

  // stage 1
  logic signed [L_W-1:0]   lx, ly, lz;
  logic signed [DIR_W-1:0] dx, dy, dz;
  logic [RAD_W-1:0]        r1;
  // stage 2
  logic signed [L_W+DIR_W-1:0] px, py, pz;
  logic signed [2*L_W-1:0]     sx, sy, sz;
  logic [RR_W-1:0]             rr2;
  // stage 3
  logic signed [DOT_W-1:0] dot3;
  logic [LL_W-1:0]         ll3;
  logic [RR_W-1:0]         rr3;
  // stage 4
  logic signed [TCA_W-1:0] tca4;
  logic [LL_W-1:0]         ll4;
  logic [RR_W-1:0]         rr4;
  // stage 5
  logic signed [TCA_W-1:0] tca5;
  logic [TM2_W-1:0]        tm2_5;
  logic [LL_W-1:0]         ll5;
  logic [RR_W-1:0]         rr5;
  // stage 6
  logic signed [TCA_W-1:0]  tca6;
  logic signed [DIFF_W-1:0] diff6;

  logic [TM_W-1:0] tm4;
  assign tm4 = tca4[TCA_W-1] ? TM_W'(-tca4) : tca4[TM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_take};
    end
    if (en) begin
      lx <= L_W'(center_x) - L_W'(origin_x);
      ly <= L_W'(center_y) - L_W'(origin_y);
      lz <= L_W'(center_z) - L_W'(origin_z);
      dx <= dir_x;
      dy <= dir_y;
      dz <= dir_z;
      r1 <= sphere_radius;

      px  <= lx * (L_W+DIR_W)'(dx);
      py  <= ly * (L_W+DIR_W)'(dy);
      pz  <= lz * (L_W+DIR_W)'(dz);
      sx  <= lx * lx;
      sy  <= ly * ly;
      sz  <= lz * lz;
      rr2 <= RR_W'(r1) * RR_W'(r1);

      dot3 <= DOT_W'(px) + DOT_W'(py) + DOT_W'(pz);
      ll3  <= LL_W'(sx) + LL_W'(sy) + LL_W'(sz);
      rr3  <= rr2;

      // arithmetic shift rounds toward minus infinity
      tca4 <= TCA_W'(dot3 >>> DIR_FRAC);
      ll4  <= ll3;
      rr4  <= rr3;

      tca5  <= tca4;
      tm2_5 <= TM2_W'(tm4) * TM2_W'(tm4);
      ll5   <= ll4;
      rr5   <= rr4;

      tca6  <= tca5;
      diff6 <= DIFF_W'(rr5) + DIFF_W'(tm2_5) - DIFF_W'(ll5);
    end
  end

  always_comb begin
    head.valid = vld[5];
    head.neg   = diff6[DIFF_W-1];
    head.tca   = tca6;
    head.x     = diff6[X_W-1:0];
    head.rem   = '0;
    head.root  = '0;
  end

endmodule
`default_nettype wire

// ===== design/ris_sqrt_cell.sv =====
// one digit step of the floor square root, two radicand bits per cell
// depends on ris_pkg
`default_nettype none
module ris_sqrt_cell (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire ris_pkg::sqrt_word_t d_in,
  output ris_pkg::sqrt_word_t d_out
);
  import ris_pkg::*;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;
  sqrt_word_t       nxt;

  always_comb begin
    rem_sh = {d_in.rem[REM_W-3:0], d_in.x[X_W-1 -: 2]};
    trial  = {1'b0, d_in.root, 2'b01};
    fits   = rem_sh >= trial;
    nxt       = d_in;
    nxt.x     = {d_in.x[X_W-3:0], 2'b00};
    nxt.rem   = fits ? rem_sh - trial : rem_sh;
    nxt.root  = {d_in.root[ROOT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out.valid <= d_in.valid;
    end
    if (en) begin
      d_out.neg  <= nxt.neg;
      d_out.tca  <= nxt.tca;
      d_out.x    <= nxt.x;
      d_out.rem  <= nxt.rem;
      d_out.root <= nxt.root;
    end
  end

endmodule
`default_nettype wire
